// File: rtl/mbs_pkg.sv
// Shared constants, codes and types for the maze backtracker step block.
// Used by maze_backtracker_step; depends on nothing else.
package mbs_pkg;

    localparam int MAX_GRID    = 64;
    localparam int GRID_W      = $clog2(MAX_GRID);
    localparam int NODE_AW     = 2 * GRID_W;
    localparam int NODE_DEPTH  = MAX_GRID * MAX_GRID;
    localparam int STACK_DEPTH = 1024;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = STACK_AW + 1;
    localparam int SIZE_W      = 7;
    localparam int LINK_W      = 4;
    localparam int NODE_W      = LINK_W + 1;

    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_CARVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic REG_GRID_SIZE = 1'b0;

    typedef struct packed {
        logic              is_wall;
        logic              finished;
        logic [GRID_W-1:0] next_col;
        logic [GRID_W-1:0] next_row;
    } res_t;

    function automatic logic [1:0] order_dir(input logic [1:0] choice, input logic [1:0] k);
        logic [1:0] d;
        begin
            d = DIR_UP;
            unique case (choice)
                2'd0:
                begin
                    unique case (k)
                        2'd0: d = DIR_UP;
                        2'd1: d = DIR_DOWN;
                        2'd2: d = DIR_RIGHT;
                        default: d = DIR_LEFT;
                    endcase
                end
                2'd1:
                begin
                    unique case (k)
                        2'd0: d = DIR_DOWN;
                        2'd1: d = DIR_UP;
                        2'd2: d = DIR_RIGHT;
                        default: d = DIR_LEFT;
                    endcase
                end
                2'd2:
                begin
                    unique case (k)
                        2'd0: d = DIR_RIGHT;
                        2'd1: d = DIR_UP;
                        2'd2: d = DIR_DOWN;
                        default: d = DIR_LEFT;
                    endcase
                end
                default:
                begin
                    unique case (k)
                        2'd0: d = DIR_LEFT;
                        2'd1: d = DIR_UP;
                        2'd2: d = DIR_DOWN;
                        default: d = DIR_RIGHT;
                    endcase
                end
            endcase
            return d;
        end
    endfunction

endpackage

// File: rtl/maze_backtracker_step.sv
// Top level of the maze backtracker step block: grid memories, path stack and sequencer.
// Depends on mbs_pkg for constants, codes and the result type.
//
// Commands arrive on the s_axis channel, one transfer per command, and each command
// produces exactly one result transfer on the m_axis channel. The command code travels
// in s_axis_tuser. Register grid_size sits at APB address 0 and may be written only
// while the block is idle.
// The grid lives in two single-port synchronous memories (visited flag plus links per
// node, and the wall map), and the path stack in a third. One command is processed at
// a time, at most one access per memory per cycle. A command inside the grid first
// fetches its node; a step then probes neighbors in priority order, one read each, plus
// a stack pop when no neighbor is free. A step outside the grid only pops the stack.
// After reset a clearing pass writes every node to its reset value; s_axis_tready
// stays low until it completes, while APB writes are taken as ever.
// The result waits in an output register; the next command is accepted while it
// waits, and a stalled receiver only holds the sequencer at the point where the
// following result must be handed over.
module maze_backtracker_step
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row[5:0], col[11:6], choice[13:12], zero[15:14]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // next_row[5:0], next_col[11:6], finished[12],
                                        // is_wall[13], zero[15:14]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int GW = mbs_pkg::GRID_W;
    localparam int AW = mbs_pkg::NODE_AW;
    localparam int SW = mbs_pkg::SIZE_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CUR   = 4'd2;
    localparam logic [3:0] ST_CURD  = 4'd3;
    localparam logic [3:0] ST_NB    = 4'd4;
    localparam logic [3:0] ST_NBD   = 4'd5;
    localparam logic [3:0] ST_WRCUR = 4'd6;
    localparam logic [3:0] ST_POP   = 4'd7;
    localparam logic [3:0] ST_POPD  = 4'd8;
    localparam logic [3:0] ST_CARVE = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [mbs_pkg::NODE_W-1:0] node_mem  [mbs_pkg::NODE_DEPTH];
    logic                       wall_mem  [mbs_pkg::NODE_DEPTH];
    logic [AW-1:0]              stack_mem [mbs_pkg::STACK_DEPTH];

    logic [3:0]                   state_reg, state_next;
    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]                gs_reg;
    logic [1:0]                   cmd_reg, cmd_next;
    logic [GW-1:0]                row_reg, row_next;
    logic [GW-1:0]                col_reg, col_next;
    logic [1:0]                   choice_reg, choice_next;
    logic [1:0]                   k_reg, k_next;
    logic [1:0]                   dir_reg, dir_next;
    logic                         found_reg, found_next;
    logic [mbs_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic [GW-1:0]                nb_row_reg, nb_row_next;
    logic [GW-1:0]                nb_col_reg, nb_col_next;
    logic [mbs_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    mbs_pkg::res_t                res_reg, res_next;
    mbs_pkg::res_t                out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [mbs_pkg::NODE_W-1:0]   node_rdata_reg;
    logic                         wall_rdata_reg;
    logic [AW-1:0]                stack_rdata_reg;

    logic [AW-1:0]                node_addr;
    logic                         node_we;
    logic [mbs_pkg::NODE_W-1:0]   node_wdata;
    logic [AW-1:0]                wall_addr;
    logic                         wall_we;
    logic                         wall_wdata;
    logic [mbs_pkg::STACK_AW-1:0] stack_addr;
    logic                         stack_we;
    logic [AW-1:0]                stack_wdata;

    logic [SW-1:0]                size_raw;
    logic [SW-1:0]                size_eff;
    logic [GW-1:0]                in_row;
    logic [GW-1:0]                in_col;
    logic                         in_inside;
    logic                         in_xfer;
    logic [1:0]                   dir;
    logic                         nb_ok;
    logic [GW-1:0]                nb_row;
    logic [GW-1:0]                nb_col;
    logic [mbs_pkg::COUNT_W-1:0]  cnt_m1;
    logic                         carve_ok;
    logic [AW-1:0]                carve_addr;
    logic                         cfg_we;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == mbs_pkg::REG_GRID_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= SW'(mbs_pkg::MAX_GRID);
        end
        else if (cfg_we)
        begin
            gs_reg <= pwdata[SW-1:0];
        end
    end

    assign prdata = (paddr[2] == mbs_pkg::REG_GRID_SIZE) ? {{(32-SW){1'b0}}, gs_reg} : 32'd0;

    // Grid size and bounds
    assign size_raw  = gs_reg & ~SW'(1);
    assign size_eff  = (size_raw > SW'(mbs_pkg::MAX_GRID)) ? SW'(mbs_pkg::MAX_GRID) : size_raw;
    assign in_row    = s_axis_tdata[GW-1:0];
    assign in_col    = s_axis_tdata[2*GW-1:GW];
    assign in_inside = ({1'b0, in_row} < size_eff) && ({1'b0, in_col} < size_eff);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    // Neighbor two nodes away in the current probe direction
    assign dir = mbs_pkg::order_dir(choice_reg, k_reg);

    always_comb
    begin
        nb_row = row_reg;
        nb_col = col_reg;
        nb_ok  = 1'b0;
        unique case (dir)
            mbs_pkg::DIR_UP:
            begin
                nb_ok  = (row_reg >= GW'(2));
                nb_row = row_reg - GW'(2);
            end
            mbs_pkg::DIR_DOWN:
            begin
                nb_ok  = (({1'b0, row_reg} + SW'(2)) < size_eff);
                nb_row = row_reg + GW'(2);
            end
            mbs_pkg::DIR_RIGHT:
            begin
                nb_ok  = (({1'b0, col_reg} + SW'(2)) < size_eff);
                nb_col = col_reg + GW'(2);
            end
            default:
            begin
                nb_ok  = (col_reg >= GW'(2));
                nb_col = col_reg - GW'(2);
            end
        endcase
    end

    // Wall node between the current node and a linked neighbor
    always_comb
    begin
        carve_ok   = 1'b0;
        carve_addr = {row_reg, col_reg};
        unique case (k_reg)
            mbs_pkg::DIR_UP:
            begin
                carve_ok   = cur_reg[mbs_pkg::DIR_UP] && (row_reg != '0);
                carve_addr = {row_reg - GW'(1), col_reg};
            end
            mbs_pkg::DIR_DOWN:
            begin
                carve_ok   = cur_reg[mbs_pkg::DIR_DOWN] && (row_reg != '1);
                carve_addr = {row_reg + GW'(1), col_reg};
            end
            mbs_pkg::DIR_RIGHT:
            begin
                carve_ok   = cur_reg[mbs_pkg::DIR_RIGHT] && (col_reg != '1);
                carve_addr = {row_reg, col_reg + GW'(1)};
            end
            default:
            begin
                carve_ok   = cur_reg[mbs_pkg::DIR_LEFT] && (col_reg != '0);
                carve_addr = {row_reg, col_reg - GW'(1)};
            end
        endcase
    end

    assign cnt_m1 = cnt_reg - mbs_pkg::COUNT_W'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        choice_next    = choice_reg;
        k_next         = k_reg;
        dir_next       = dir_reg;
        found_next     = found_reg;
        cur_next       = cur_reg;
        nb_row_next    = nb_row_reg;
        nb_col_next    = nb_col_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        node_addr   = {row_reg, col_reg};
        node_we     = 1'b0;
        node_wdata  = cur_reg;
        wall_addr   = {row_reg, col_reg};
        wall_we     = 1'b0;
        wall_wdata  = 1'b0;
        stack_addr  = cnt_reg[mbs_pkg::STACK_AW-1:0];
        stack_we    = 1'b0;
        stack_wdata = {nb_row_reg, nb_col_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                node_addr  = clr_cnt_reg;
                node_we    = 1'b1;
                node_wdata = '0;
                wall_addr  = clr_cnt_reg;
                wall_we    = 1'b1;
                wall_wdata = clr_cnt_reg[GW] | clr_cnt_reg[0];
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(mbs_pkg::NODE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next    = s_axis_tuser;
                    row_next    = in_row;
                    col_next    = in_col;
                    choice_next = s_axis_tdata[2*GW+1:2*GW];
                    k_next      = 2'd0;
                    found_next  = 1'b0;
                    res_next    = '0;
                    priority case (1'b1)
                        (s_axis_tuser == mbs_pkg::CMD_STEP):
                        begin
                            state_next = in_inside ? ST_CUR : ST_POP;
                        end
                        (s_axis_tuser == mbs_pkg::CMD_CARVE):
                        begin
                            state_next = in_inside ? ST_CUR : ST_OUT;
                        end
                        (s_axis_tuser == mbs_pkg::CMD_READ):
                        begin
                            res_next.is_wall = 1'b1;
                            state_next = in_inside ? ST_CUR : ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_CUR:
            begin
                state_next = ST_CURD;
            end
            ST_CURD:
            begin
                cur_next = node_rdata_reg;
                k_next   = 2'd0;
                priority case (1'b1)
                    (cmd_reg == mbs_pkg::CMD_READ):
                    begin
                        res_next.is_wall = wall_rdata_reg;
                        state_next = ST_OUT;
                    end
                    (cmd_reg == mbs_pkg::CMD_CARVE):
                    begin
                        state_next = ST_CARVE;
                    end
                    default:
                    begin
                        state_next = ST_NB;
                    end
                endcase
            end
            ST_NB:
            begin
                if (nb_ok)
                begin
                    node_addr   = {nb_row, nb_col};
                    nb_row_next = nb_row;
                    nb_col_next = nb_col;
                    state_next  = ST_NBD;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = ST_WRCUR;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_NBD:
            begin
                if (!node_rdata_reg[mbs_pkg::LINK_W])
                begin
                    found_next = 1'b1;
                    dir_next   = dir;
                    state_next = ST_WRCUR;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = ST_WRCUR;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_NB;
                end
            end
            ST_WRCUR:
            begin
                node_we    = 1'b1;
                node_wdata = {1'b1, cur_reg[mbs_pkg::LINK_W-1:0]
                              | (found_reg ? (mbs_pkg::LINK_W'(1) << dir_reg)
                                           : mbs_pkg::LINK_W'(0))};
                if (found_reg)
                begin
                    if (cnt_reg < mbs_pkg::COUNT_W'(mbs_pkg::STACK_DEPTH))
                    begin
                        stack_we = 1'b1;
                        cnt_next = cnt_reg + mbs_pkg::COUNT_W'(1);
                    end
                    res_next.next_row = nb_row_reg;
                    res_next.next_col = nb_col_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next   = cnt_m1;
                    stack_addr = cnt_m1[mbs_pkg::STACK_AW-1:0];
                    state_next = ST_POPD;
                end
                else
                begin
                    res_next.finished = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_POPD:
            begin
                res_next.next_row = stack_rdata_reg[AW-1:GW];
                res_next.next_col = stack_rdata_reg[GW-1:0];
                state_next = ST_OUT;
            end
            ST_CARVE:
            begin
                wall_addr  = carve_addr;
                wall_we    = carve_ok;
                wall_wdata = 1'b0;
                if (k_reg == 2'd0)
                begin
                    node_we    = 1'b1;
                    node_wdata = {cur_reg[mbs_pkg::LINK_W], mbs_pkg::LINK_W'(0)};
                end
                if (k_reg == 2'd3)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        choice_reg <= choice_next;
        dir_reg    <= dir_next;
        cur_reg    <= cur_next;
        nb_row_reg <= nb_row_next;
        nb_col_reg <= nb_col_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_addr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_addr] <= wall_wdata;
        end
        wall_rdata_reg <= wall_mem[wall_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_addr] <= stack_wdata;
        end
        stack_rdata_reg <= stack_mem[stack_addr];
    end

    // Assertions
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mbs_pkg::COUNT_W'(mbs_pkg::STACK_DEPTH))
        else $error("Path stack count exceeds its depth.");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) && (cnt_reg != '0) |=> (cnt_reg == $past(cnt_m1)))
        else $error("Pop did not decrement the stack count.");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRCUR) && found_reg
        && (cnt_reg < mbs_pkg::COUNT_W'(mbs_pkg::STACK_DEPTH))
        |=> (cnt_reg == $past(cnt_reg) + mbs_pkg::COUNT_W'(1)))
        else $error("Push did not increment the stack count.");

    a_visit_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRCUR) |-> (node_we && node_wdata[mbs_pkg::LINK_W]))
        else $error("Step did not mark the current node visited.");

endmodule
